// ===== rtl/lsac_pkg.sv =====
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types and constants for the LRU set-associative cache tag model.
// ----------------------------------------------------------------------------
`default_nettype none

package lsac_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam int COUNT_W   = 32;
    localparam int AGE_W     = 3;
    localparam int AGE_MAX   = 7;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int RESULT_W  = 2 + 3 * COUNT_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] block_bits;
        logic [3:0] ways;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] eviction_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] hit_total;
        logic               evicted;
        logic               hit;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lsac_ram.sv =====
// ----------------------------------------------------------------------------
// lsac_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]     i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsac_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsac_ctrl
// Controller: input transfer, set read, update and output register control.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic          i_modify,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic               o_m_tlast,
    output lsac_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_modify;
    logic       r_second;
    logic       r_m_tvalid;
    logic       r_m_tlast;
    logic       w_slot_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tlast   = r_m_tlast;
    assign w_slot_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.rd   = 1'b0;
        o_cmd.upd  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (w_slot_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = (r_modify && !r_second) ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_modify   <= 1'b0;
            r_second   <= 1'b0;
            r_m_tvalid <= 1'b0;
            r_m_tlast  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_modify <= i_modify;
                r_second <= 1'b0;
            end
            if (o_cmd.upd) begin
                r_m_tvalid <= 1'b1;
                r_m_tlast  <= !r_modify || r_second;
                r_second   <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.rd, o_cmd.upd}))
        else $error("More than one datapath command in a cycle.");

    a_upd_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |-> (!o_m_tvalid || i_m_tready))
        else $error("Update overwrote a result that was not transferred.");

    a_rd_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_UPD))
        else $error("Set read not followed by the update state.");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd && r_modify && !r_second) |=> (o_m_tvalid && !o_m_tlast))
        else $error("First access of a modify marked as last.");

endmodule

`default_nettype wire

// ===== rtl/lsac_dp.sv =====
// ----------------------------------------------------------------------------
// lsac_dp
// Datapath: address split, set RAM, way compare, LRU ages and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_dp #(
    parameter int MAX_SET_BITS = lsac_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsac_pkg::MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = lsac_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsac_pkg::t_cmd    i_cmd,
    input  wire lsac_pkg::t_cfg    i_cfg,
    input  wire logic [ADDRESS_BITS-1:0] i_address,
    output lsac_pkg::t_result      o_result
);

    localparam int AGE_W  = lsac_pkg::AGE_W;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int WAY_W  = 1 + AGE_W + ADDRESS_BITS;
    localparam int ROW_W  = MAX_WAYS * WAY_W;
    localparam int CW     = lsac_pkg::COUNT_W;

    logic [ADDRESS_BITS-1:0] r_addr;
    logic [ADDRESS_BITS-1:0] r_tag;
    logic [SET_W-1:0]        r_set;
    logic [NSETS-1:0]        r_row_valid;
    logic [CW-1:0]           r_hit_cnt;
    logic [CW-1:0]           r_miss_cnt;
    logic [CW-1:0]           r_evict_cnt;
    lsac_pkg::t_result       r_result;

    logic [CW-1:0]           n_hit_cnt;
    logic [CW-1:0]           n_miss_cnt;
    logic [CW-1:0]           n_evict_cnt;

    logic [2:0]              s_eff;
    logic [5:0]              tag_shift;
    logic [ADDRESS_BITS-1:0] set_idx;
    logic [SET_W-1:0]        set_c;
    logic [ADDRESS_BITS-1:0] tag_c;
    logic [NW_W-1:0]         nways;

    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        wr_row;
    logic                    row_ok;
    logic [MAX_WAYS-1:0]     way_v;
    logic [AGE_W-1:0]        way_age [MAX_WAYS];
    logic [ADDRESS_BITS-1:0] way_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0]     in_use;
    logic [MAX_WAYS-1:0]     match;
    logic [MAX_WAYS-1:0]     empty;
    logic [WAY_IW-1:0]       found;
    logic [WAY_IW-1:0]       free_way;
    logic [WAY_IW-1:0]       victim;
    logic [WAY_IW-1:0]       target;
    logic [AGE_W:0]          ref_age;
    logic                    hit;
    logic                    any_free;
    logic                    evicted;
    logic [AGE_W-1:0]        age_n;
    logic                    valid_n;
    logic [ADDRESS_BITS-1:0] tag_n;

    always_comb begin
        if (i_cfg.ways == '0) begin
            nways = NW_W'(1);
        end else if (int'(i_cfg.ways) > MAX_WAYS) begin
            nways = NW_W'(MAX_WAYS);
        end else begin
            nways = NW_W'(i_cfg.ways);
        end
        s_eff     = (int'(i_cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS)
                                                           : i_cfg.set_bits;
        tag_shift = 6'(s_eff) + 6'(i_cfg.block_bits);
        set_idx   = (int'(i_cfg.block_bits) >= ADDRESS_BITS) ? '0
                                                              : (r_addr >> i_cfg.block_bits);
        set_c     = set_idx[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
        tag_c     = (int'(tag_shift) >= ADDRESS_BITS) ? '0 : (r_addr >> tag_shift);
    end

    lsac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.upd),
        .i_wr_addr (r_set),
        .i_wr_data (wr_row),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (set_c),
        .o_rd_data (rd_row)
    );

    always_comb begin
        row_ok = r_row_valid[r_set];
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_v[w]   = row_ok & rd_row[w*WAY_W];
            way_age[w] = row_ok ? rd_row[w*WAY_W+1 +: AGE_W] : '0;
            way_tag[w] = rd_row[w*WAY_W+1+AGE_W +: ADDRESS_BITS];
            in_use[w]  = int'(nways) > w;
            match[w]   = in_use[w] & way_v[w] & (way_tag[w] == r_tag);
            empty[w]   = in_use[w] & ~way_v[w];
        end

        found    = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                found = WAY_IW'(w);
            end
            if (empty[w]) begin
                free_way = WAY_IW'(w);
            end
        end

        victim = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (way_age[w] > way_age[victim])) begin
                victim = WAY_IW'(w);
            end
        end

        hit      = |match;
        any_free = |empty;
        evicted  = !hit && !any_free;

        if (hit) begin
            ref_age = {1'b0, way_age[found]};
            target  = found;
        end else if (any_free) begin
            ref_age = (AGE_W+1)'(lsac_pkg::AGE_MAX + 1);
            target  = free_way;
        end else begin
            ref_age = {1'b0, way_age[victim]};
            target  = victim;
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            age_n   = way_age[w];
            valid_n = way_v[w];
            tag_n   = way_tag[w];
            if (in_use[w] && way_v[w] && ({1'b0, way_age[w]} < ref_age)
                && (way_age[w] != AGE_W'(lsac_pkg::AGE_MAX))) begin
                age_n = way_age[w] + AGE_W'(1);
            end
            if (target == WAY_IW'(w)) begin
                valid_n = 1'b1;
                age_n   = '0;
                tag_n   = r_tag;
            end
            wr_row[w*WAY_W +: WAY_W] = {tag_n, age_n, valid_n};
        end

        n_hit_cnt   = (hit && (r_hit_cnt != '1)) ? r_hit_cnt + CW'(1) : r_hit_cnt;
        n_miss_cnt  = (!hit && (r_miss_cnt != '1)) ? r_miss_cnt + CW'(1) : r_miss_cnt;
        n_evict_cnt = (evicted && (r_evict_cnt != '1)) ? r_evict_cnt + CW'(1)
                                                       : r_evict_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_address;
        end
        if (i_cmd.rd) begin
            r_set <= set_c;
            r_tag <= tag_c;
        end
        if (i_cmd.upd) begin
            r_result.hit            <= hit;
            r_result.evicted        <= evicted;
            r_result.hit_total      <= n_hit_cnt;
            r_result.miss_total     <= n_miss_cnt;
            r_result.eviction_total <= n_evict_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (i_cmd.upd) begin
            r_row_valid[r_set] <= 1'b1;
            r_hit_cnt          <= n_hit_cnt;
            r_miss_cnt         <= n_miss_cnt;
            r_evict_cnt        <= n_evict_cnt;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/lru_set_assoc_cache_sim_core.sv =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_core
// Tag store of a set-associative cache with LRU replacement and hit, miss
// and eviction totals.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer rule               Content
//  s        in         i_s_tvalid & o_s_tready     address, tuser = modify flag
//  m        out        o_m_tvalid & i_m_tready     one result per access, two per modify, tlast
//  apb      in         psel & penable & pwrite     set_bits, block_bits, ways
//
//  A single access steps through transfer, set read and update.
//  A modify repeats the set read and update once.
//  The set RAM port (read, then write back in the update) sets this sequence.
//  Reset clears per-set valid flags at once, so no clearing pass is needed.
//  The update waits while the output register holds a result not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_set_assoc_cache_sim_core #(
    parameter int MAX_SET_BITS = lsac_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsac_pkg::MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = lsac_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // address
    input  wire logic [((ADDRESS_BITS + 7) / 8) * 8-1:0] i_s_tdata,
    // func
    input  wire logic [0:0] i_s_tuser,

    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // hit, evicted, hit_total, miss_total, eviction_total, zero fill
    output logic [lsac_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic      o_m_tlast,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lsac_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lsac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lsac_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    lsac_pkg::t_cfg    r_cfg;
    lsac_pkg::t_cmd    cmd;
    lsac_pkg::t_result result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= '0;
            r_cfg.block_bits <= '0;
            r_cfg.ways       <= 4'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                lsac_pkg::REG_SET_BITS:   r_cfg.set_bits   <= pwdata[2:0];
                lsac_pkg::REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[4:0];
                lsac_pkg::REG_WAYS:       r_cfg.ways       <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lsac_pkg::REG_SET_BITS:   prdata = {29'd0, r_cfg.set_bits};
            lsac_pkg::REG_BLOCK_BITS: prdata = {27'd0, r_cfg.block_bits};
            lsac_pkg::REG_WAYS:       prdata = {28'd0, r_cfg.ways};
            default:                  prdata = '0;
        endcase
    end

    lsac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_modify   (i_s_tuser[0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tlast  (o_m_tlast),
        .o_cmd      (cmd)
    );

    lsac_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (r_cfg),
        .i_address (i_s_tdata[ADDRESS_BITS-1:0]),
        .o_result  (result)
    );

    assign o_m_tdata = {{(lsac_pkg::OUT_TDATA_W - lsac_pkg::RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LRU set-associative cache tag model. A
// behavioral copy of the tag store predicts hit, eviction and the running
// totals for every access. Outputs are compared field by field against the
// oldest pending prediction. A directed table runs first. Randomized phases
// follow, each with its own geometry and one of four idle patterns on the streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SET_BITS_CAP = lsac_pkg::MAX_SET_BITS_DEF;
    localparam int         WAYS_CAP     = lsac_pkg::MAX_WAYS_DEF;
    localparam int         NUM_LINES    = (1 << SET_BITS_CAP) * WAYS_CAP;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_ITEMS  = 205;
    localparam logic       FN_SINGLE    = 1'b0;
    localparam logic       FN_MODIFY    = 1'b1;
    localparam logic [2:0] LRU_OLDEST   = 3'(lsac_pkg::AGE_MAX);

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [31:0]                      i_s_tdata  = '0;
    logic [0:0]                       i_s_tuser  = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [lsac_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                             o_m_tlast;
    logic                             psel       = 1'b0;
    logic                             penable    = 1'b0;
    logic                             pwrite     = 1'b0;
    logic [lsac_pkg::PADDR_W-1:0]     paddr      = '0;
    logic [lsac_pkg::PDATA_W-1:0]     pwdata     = '0;
    logic [lsac_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;

    lru_set_assoc_cache_sim_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic              last;
        lsac_pkg::t_result res;
    } t_expect;

    typedef struct {
        logic        cfg;
        logic [1:0]  idx;
        logic        func;
        logic [31:0] data;
        logic        known;
        logic [1:0]  k_hit;
        logic [1:0]  k_ev;
    } t_row;

    logic        line_valid [NUM_LINES];
    logic [31:0] line_tag   [NUM_LINES];
    logic [2:0]  line_age   [NUM_LINES];
    logic [31:0] hit_count      = '0;
    logic [31:0] miss_count     = '0;
    logic [31:0] eviction_count = '0;
    logic [2:0]  cfg_set_bits   = 3'd0;
    logic [4:0]  cfg_block_bits = 5'd0;
    logic [3:0]  cfg_ways       = 4'd1;

    t_expect           pending_results [$];
    logic [31:0]       tag_pool [12];
    int                pool_size;
    int                mismatches     = 0;
    int                quiet_cycles   = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;
    logic              hold_go        = 1'b0;
    t_expect           want;
    lsac_pkg::t_result got;

    // Register writes interleaved with accesses whose outcome is obvious
    // from the geometry: one set and one way after reset, then more ways,
    // ways of zero and above the maximum, and offsets that swallow the tag; the closing accesses are left to the model.
    t_row plan [0:25] = '{
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0000, 1'b1, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0000, 1'b1, 2'b01, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'hFFFF_FFFF, 1'b1, 2'b00, 2'b01},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_MODIFY, 32'hFFFF_FFFF, 1'b1, 2'b11, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_MODIFY, 32'h1234_5678, 1'b1, 2'b10, 2'b01},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h8000_0000, 1'b1, 2'b00, 2'b01},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0001, 1'b1, 2'b00, 2'b01},
        '{1'b1, lsac_pkg::REG_WAYS,     FN_SINGLE, 32'd2,         1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0010, 1'b1, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0020, 1'b1, 2'b00, 2'b01},
        '{1'b1, lsac_pkg::REG_WAYS,     FN_SINGLE, 32'd0,         1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0020, 1'b1, 2'b01, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0010, 1'b1, 2'b00, 2'b01},
        '{1'b1, lsac_pkg::REG_WAYS,     FN_SINGLE, 32'd15,        1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0010, 1'b1, 2'b01, 2'b00},
        '{1'b1, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'd7,         1'b0, 2'b00, 2'b00},
        '{1'b1, lsac_pkg::REG_BLOCK_BITS, FN_SINGLE, 32'd31,      1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h0000_0000, 1'b1, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h7FFF_FFFF, 1'b1, 2'b01, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_MODIFY, 32'h8000_0000, 1'b1, 2'b10, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'hFFFF_FFFF, 1'b1, 2'b01, 2'b00},
        '{1'b1, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'd3,         1'b0, 2'b00, 2'b00},
        '{1'b1, lsac_pkg::REG_BLOCK_BITS, FN_SINGLE, 32'd4,       1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_MODIFY, 32'hA5A5_A5A5, 1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'h5A5A_5A5A, 1'b0, 2'b00, 2'b00},
        '{1'b0, lsac_pkg::REG_SET_BITS, FN_SINGLE, 32'hA5A5_A5A0, 1'b0, 2'b00, 2'b00}
    };

    int phase_set_bits   [8] = '{0, 6, 7, 3, 2, 1, 6, 0};
    int phase_block_bits [8] = '{0, 26, 31, 5, 0, 29, 0, 0};
    int phase_ways       [8] = '{1, 8, 15, 4, 0, 2, 8, 1};

    initial begin
        for (int i = 0; i < NUM_LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_age[i]   = '0;
        end
    end

    function automatic int active_set_bits();
        return (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(cfg_set_bits);
    endfunction

    function automatic int active_ways();
        if (cfg_ways == 0) return 1;
        return (cfg_ways > WAYS_CAP) ? WAYS_CAP : int'(cfg_ways);
    endfunction

    function automatic logic [31:0] bump(logic [31:0] count);
        return (count == '1) ? count : count + 32'd1;
    endfunction

    function automatic void age_younger(int base, int nways, int pivot);
        for (int w = 0; w < nways; w++) begin
            if (line_valid[base + w] && int'(line_age[base + w]) < pivot
                    && line_age[base + w] != LRU_OLDEST) begin
                line_age[base + w] = line_age[base + w] + 3'd1;
            end
        end
    endfunction

    function automatic lsac_pkg::t_result cache_access(logic [31:0] addr);
        int                sbits;
        int                nways;
        int                shamt;
        int                base;
        int                found;
        int                free_way;
        int                victim;
        logic [31:0]       tag;
        logic [31:0]       row;
        lsac_pkg::t_result r;
        sbits    = active_set_bits();
        nways    = active_ways();
        shamt    = sbits + int'(cfg_block_bits);
        tag      = (shamt >= 32) ? 32'd0 : addr >> shamt;
        row      = (addr >> cfg_block_bits) & ((32'd1 << sbits) - 32'd1);
        base     = int'(row) * WAYS_CAP;
        found    = -1;
        free_way = -1;
        victim   = 0;
        r        = '0;
        for (int w = 0; w < nways; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag && found < 0) found = w;
            if (!line_valid[base + w] && free_way < 0) free_way = w;
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            hit_count = bump(hit_count);
            age_younger(base, nways, int'(line_age[base + found]));
            line_age[base + found] = '0;
        end else begin
            miss_count = bump(miss_count);
            if (free_way >= 0) begin
                age_younger(base, nways, lsac_pkg::AGE_MAX + 1);
                victim = free_way;
            end else begin
                for (int w = 1; w < nways; w++) begin
                    if (line_age[base + w] > line_age[base + victim]) victim = w;
                end
                r.evicted = 1'b1;
                eviction_count = bump(eviction_count);
                age_younger(base, nways, int'(line_age[base + victim]));
            end
            line_valid[base + victim] = 1'b1;
            line_tag[base + victim]   = tag;
            line_age[base + victim]   = '0;
        end
        r.hit_total      = hit_count;
        r.miss_total     = miss_count;
        r.eviction_total = eviction_count;
        return r;
    endfunction

    // Most addresses are built from a small tag pool and a few sets so that
    // hits, fills and evictions all occur; the rest are fully random.
    function automatic logic [31:0] pick_address();
        int          sbits;
        int          row;
        logic [63:0] tag;
        logic [63:0] a;
        sbits = active_set_bits();
        if ($urandom_range(0, 4) == 0) return $urandom;
        if ($urandom_range(0, 2) == 0) row = $urandom_range(0, (1 << sbits) - 1);
        else row = $urandom_range(0, 1) & ((1 << sbits) - 1);
        tag = 64'(tag_pool[$urandom_range(0, pool_size - 1)]);
        a = (tag << (sbits + cfg_block_bits)) | (64'(row) << cfg_block_bits)
            | (64'($urandom) & ((64'd1 << cfg_block_bits) - 64'd1));
        return a[31:0];
    endfunction

    function automatic void report_mismatch(string field, logic [31:0] exp_v,
                                            logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch in %s: expected %0h, got %0h", $time, field, exp_v, act_v);
        end
    endfunction

    task automatic send_item(input logic func, input logic [31:0] addr, input logic known,
                             input logic [1:0] k_hit, input logic [1:0] k_ev);
        logic              taken;
        int                n;
        lsac_pkg::t_result r;
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= func;
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end while (!taken);
        n = (func == FN_MODIFY) ? 2 : 1;
        for (int k = 0; k < n; k++) begin
            r = cache_access(addr);
            if (known) begin
                r.hit     = k_hit[k];
                r.evicted = k_ev[k];
            end
            pending_results.push_back(t_expect'{last: (k == n - 1), res: r});
        end
    endtask

    task automatic wait_for_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            lsac_pkg::REG_SET_BITS: begin
                cfg_set_bits = val[2:0];
            end
            lsac_pkg::REG_BLOCK_BITS: begin
                cfg_block_bits = val[4:0];
            end
            lsac_pkg::REG_WAYS: begin
                cfg_ways = val[3:0];
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(1, 100) > recv_stall_pct);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = lsac_pkg::t_result'(o_m_tdata[lsac_pkg::RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", 32'd0, got.hit_total);
            end else begin
                want = pending_results.pop_front();
                if (got.hit != want.res.hit)
                    report_mismatch("hit", 32'(want.res.hit), 32'(got.hit));
                if (got.evicted != want.res.evicted)
                    report_mismatch("evicted", 32'(want.res.evicted), 32'(got.evicted));
                if (got.hit_total != want.res.hit_total)
                    report_mismatch("hit_total", want.res.hit_total, got.hit_total);
                if (got.miss_total != want.res.miss_total)
                    report_mismatch("miss_total", want.res.miss_total, got.miss_total);
                if (got.eviction_total != want.res.eviction_total)
                    report_mismatch("eviction_total", want.res.eviction_total,
                                    got.eviction_total);
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast", 32'(want.last), 32'(o_m_tlast));
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].cfg) begin
                wait_for_idle();
                apb_write(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].func, plan[i].data, plan[i].known, plan[i].k_hit,
                          plan[i].k_ev);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            wait_for_idle();
            if (ph == 7) begin
                phase_set_bits[ph]   = $urandom_range(0, 7);
                phase_block_bits[ph] = $urandom_range(0, 31);
                phase_ways[ph]       = $urandom_range(0, 15);
            end
            apb_write(lsac_pkg::REG_SET_BITS, 32'(phase_set_bits[ph]));
            apb_write(lsac_pkg::REG_BLOCK_BITS, 32'(phase_block_bits[ph]));
            apb_write(lsac_pkg::REG_WAYS, 32'(phase_ways[ph]));
            pool_size = active_ways() + 2;
            for (int t = 0; t < 12; t++) tag_pool[t] = $urandom;
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 60) hold_go = 1'b1;
                send_item(logic'($urandom_range(0, 1)), pick_address(), 1'b0, 2'b00, 2'b00);
            end
        end

        wait_for_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
